// File: hw/rtl/led_matrix_pwm_frame_streamer_core_defines.svh
// assertion macros shared by the frame streamer rtl
`ifndef LED_MATRIX_PWM_FRAME_STREAMER_CORE_DEFINES_SVH
`define LED_MATRIX_PWM_FRAME_STREAMER_CORE_DEFINES_SVH

// same-cycle implication, checked on every rising edge out of reset
`define LMPS_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lmps check failed");

// next-cycle implication, checked on every rising edge out of reset
`define LMPS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lmps check failed");

`endif

// File: hw/rtl/lmps_pkg.sv
// shared types and constants of the led matrix frame streamer
package lmps_pkg;

  localparam int LED_COUNT_DEF   = 64;
  localparam int RESET_SLOTS_DEF = 48;
  localparam int BITS_PER_LED    = 24;
  localparam int MATRIX_SIDE     = 8;
  localparam int MAX_COORD       = 7;
  localparam int CHANNELS        = 3;
  localparam int BYTE_W          = 8;
  localparam int SLOT_W          = 6;
  localparam int BIT_IDX_W       = 5;
  localparam int DUTY_W          = 16;
  localparam int IN_TDATA_W      = 56;
  localparam int IN_TUSER_W      = 2;
  localparam int OUT_TDATA_W     = 16;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 16;

  // action codes carried in tuser
  localparam logic [IN_TUSER_W-1:0] ACT_TICK    = 2'd0;
  localparam logic [IN_TUSER_W-1:0] ACT_WRITE   = 2'd1;
  localparam logic [IN_TUSER_W-1:0] ACT_REFRESH = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ONE_DUTY  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_DUTY = 2'd1;

  typedef enum logic [1:0] {
    CMD_TICK,
    CMD_WRITE,
    CMD_REFRESH
  } cmd_kind_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EMIT,
    S_DIV
  } back_state_t;

  // color[0] is channel a, sent first
  typedef struct packed {
    cmd_kind_t                        kind;
    logic [SLOT_W-1:0]                slot;
    logic [CHANNELS-1:0][BYTE_W-1:0]  color;
    logic [BYTE_W-1:0]                divisor;
    logic                             refresh;
  } cmd_t;

  typedef struct packed {
    logic push;
    cmd_t cmd;
  } front_req_t;

  typedef struct packed {
    logic [DUTY_W-1:0] one;
    logic [DUTY_W-1:0] zero;
  } duty_cfg_t;

  typedef struct packed {
    logic streaming;
    logic emit;
    logic div_busy;
  } back_stat_t;

endpackage

// File: hw/rtl/lmps_front.sv
// front end: takes input items, checks writes and turns them into commands
module lmps_front #(
  parameter int LED_COUNT = lmps_pkg::LED_COUNT_DEF
) (
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // column, row, color_a, color_b, color_c, divisor, refresh_after, zero pad
  input  logic [lmps_pkg::IN_TDATA_W-1:0]  in_tdata,
  // action
  input  logic [lmps_pkg::IN_TUSER_W-1:0]  in_tuser,
  input  logic                             fifo_full,
  output lmps_pkg::front_req_t             req
);
  import lmps_pkg::*;

  logic [BYTE_W-1:0] col;
  logic [BYTE_W-1:0] row;
  logic [BYTE_W-1:0] divisor;
  logic [8:0]        slot_wide;
  logic              write_ok;
  logic              accept;

  assign col     = in_tdata[7:0];
  assign row     = in_tdata[15:8];
  assign divisor = in_tdata[47:40];

  // row*8+column on the in-range bits
  assign slot_wide = 9'(row[2:0]) * 9'(MATRIX_SIDE) + 9'(col[2:0]);

  assign write_ok = (col <= BYTE_W'(MAX_COORD)) && (row <= BYTE_W'(MAX_COORD)) &&
                    (divisor != '0) && (slot_wide < 9'(LED_COUNT));

  assign in_tready = !fifo_full;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    req.cmd.slot     = slot_wide[SLOT_W-1:0];
    req.cmd.color[0] = in_tdata[23:16];
    req.cmd.color[1] = in_tdata[31:24];
    req.cmd.color[2] = in_tdata[39:32];
    req.cmd.divisor  = divisor;
    req.cmd.refresh  = in_tdata[48];
    req.cmd.kind     = CMD_REFRESH;
    req.push         = 1'b0;
    unique case (in_tuser)
      ACT_TICK: begin
        req.cmd.kind = CMD_TICK;
        req.push     = accept;
      end
      ACT_WRITE: begin
        req.cmd.kind = CMD_WRITE;
        req.push     = accept && write_ok;
      end
      ACT_REFRESH: begin
        req.cmd.kind = CMD_REFRESH;
        req.push     = accept;
      end
      default: begin
        // unused action code is dropped
        req.cmd.kind = CMD_REFRESH;
        req.push     = 1'b0;
      end
    endcase
  end

endmodule

// File: hw/rtl/lmps_fifo.sv
// two-entry command queue between front and back
module lmps_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  lmps_pkg::front_req_t req,
  input  logic                pop,
  output lmps_pkg::cmd_t      head,
  output logic                empty,
  output logic                full
);
  import lmps_pkg::*;

  localparam int DEPTH = 2;
  localparam int AW    = 1;

  cmd_t              entry_r [DEPTH];
  logic [AW-1:0]     wr_ptr_r;
  logic [AW-1:0]     rd_ptr_r;
  logic [AW:0]       cnt_r;
  logic [AW-1:0]     wr_ptr_nxt;
  logic [AW-1:0]     rd_ptr_nxt;
  logic [AW:0]       cnt_nxt;
  logic              do_push;
  logic              do_pop;

  assign empty   = (cnt_r == '0);
  assign full    = (cnt_r == (AW+1)'(DEPTH));
  assign head    = entry_r[rd_ptr_r];
  assign do_push = req.push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + (AW+1)'(do_push) - (AW+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= req.cmd;
    end
  end

endmodule

// File: hw/rtl/lmps_div.sv
// restoring divider, one quotient bit per cycle on all three channels
module lmps_div (
  input  logic                                               clk,
  input  logic                                               rst_n,
  input  logic                                               start,
  input  logic [lmps_pkg::CHANNELS-1:0][lmps_pkg::BYTE_W-1:0] dvd,
  input  logic [lmps_pkg::BYTE_W-1:0]                        dsr,
  output logic                                               busy,
  output logic                                               done,
  output logic [lmps_pkg::CHANNELS-1:0][lmps_pkg::BYTE_W-1:0] quo
);
  import lmps_pkg::*;

  localparam int CNT_W = $clog2(BYTE_W);

  logic [CHANNELS-1:0][BYTE_W-1:0] rem_r;
  logic [CHANNELS-1:0][BYTE_W-1:0] quo_r;
  logic [CHANNELS-1:0][BYTE_W-1:0] rem_nxt;
  logic [CHANNELS-1:0][BYTE_W-1:0] quo_nxt;
  logic [BYTE_W-1:0]               dsr_r;
  logic [CNT_W-1:0]                cnt_r;
  logic                            busy_r;
  logic                            done_r;

  // one restoring step per lane
  always_comb begin
    logic [BYTE_W:0] shifted;
    for (int i = 0; i < CHANNELS; i++) begin
      shifted = {rem_r[i], quo_r[i][BYTE_W-1]};
      if (shifted >= {1'b0, dsr_r}) begin
        rem_nxt[i] = BYTE_W'(shifted - {1'b0, dsr_r});
        quo_nxt[i] = {quo_r[i][BYTE_W-2:0], 1'b1};
      end else begin
        rem_nxt[i] = shifted[BYTE_W-1:0];
        quo_nxt[i] = {quo_r[i][BYTE_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == CNT_W'(BYTE_W-1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(BYTE_W-1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dvd;
      rem_r <= '0;
      dsr_r <= dsr;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quo  = quo_r;

endmodule

// File: hw/rtl/lmps_back.sv
// back end: frame store, divider, refresh sequencer and output register
module lmps_back #(
  parameter int LED_COUNT   = lmps_pkg::LED_COUNT_DEF,
  parameter int RESET_SLOTS = lmps_pkg::RESET_SLOTS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  lmps_pkg::cmd_t                    head,
  input  logic                              fifo_empty,
  output logic                              pop,
  input  lmps_pkg::duty_cfg_t               duty,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [lmps_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic                              out_tlast,
  output lmps_pkg::back_stat_t              stat
);
  import lmps_pkg::*;

  localparam int LED_AW = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
  localparam int RS_W   = (RESET_SLOTS > 1) ? $clog2(RESET_SLOTS) : 1;

  back_state_t state_r, state_nxt;

  // frame store and its per-entry valid bits
  logic [BITS_PER_LED-1:0]  mem [LED_COUNT];
  logic [BITS_PER_LED-1:0]  rdata_r;
  logic [LED_COUNT-1:0]     valid_r;

  logic                     streaming_r, streaming_nxt;
  logic                     rst_phase_r, rst_phase_nxt;
  logic [LED_AW-1:0]        led_r, led_nxt;
  logic [BIT_IDX_W-1:0]     bit_r, bit_nxt;
  logic [RS_W-1:0]          rst_r, rst_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [DUTY_W-1:0]        out_duty_r, out_duty_nxt;
  logic                     out_last_r, out_last_nxt;
  logic [SLOT_W-1:0]        pend_slot_r;
  logic                     pend_refresh_r;

  logic                     div_start;
  logic                     div_busy;
  logic                     div_done;
  logic [CHANNELS-1:0][BYTE_W-1:0] div_quo;

  logic                     emit;
  logic                     store;
  logic                     start_stream;
  logic [BITS_PER_LED-1:0]  led_word;
  logic                     data_bit;
  logic                     bit_last;
  logic                     led_last;
  logic                     word_last;
  logic [DUTY_W-1:0]        word;

  lmps_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .dvd   (head.color),
    .dsr   (head.divisor),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (div_quo)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (!fifo_empty) begin
          if (head.kind == CMD_TICK && streaming_r) begin
            state_nxt = S_EMIT;
          end else if (head.kind == CMD_WRITE && !streaming_r) begin
            state_nxt = S_DIV;
          end
        end
      end
      S_EMIT: begin
        if (emit) state_nxt = S_IDLE;
      end
      S_DIV: begin
        if (div_done) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    pop          = 1'b0;
    div_start    = 1'b0;
    start_stream = 1'b0;
    emit         = 1'b0;
    store        = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        pop = !fifo_empty;
        if (!fifo_empty) begin
          div_start    = (head.kind == CMD_WRITE) && !streaming_r;
          start_stream = (head.kind == CMD_REFRESH) && !streaming_r;
        end
      end
      S_EMIT:  emit  = !out_valid_r || out_tready;
      S_DIV:   store = div_done;
      default: pop   = 1'b0;
    endcase
  end

  // word for the current slot
  always_comb begin
    led_word  = valid_r[led_r] ? rdata_r : '0;
    data_bit  = led_word[BIT_IDX_W'(BITS_PER_LED-1) - bit_r];
    bit_last  = (bit_r == BIT_IDX_W'(BITS_PER_LED-1));
    led_last  = (led_r == LED_AW'(LED_COUNT-1));
    if (rst_phase_r) begin
      word      = duty.zero;
      word_last = (rst_r == RS_W'(RESET_SLOTS-1));
    end else begin
      word      = data_bit ? duty.one : duty.zero;
      word_last = (RESET_SLOTS == 0) && led_last && bit_last;
    end
  end

  // slot sequencing
  always_comb begin
    streaming_nxt = streaming_r;
    rst_phase_nxt = rst_phase_r;
    led_nxt       = led_r;
    bit_nxt       = bit_r;
    rst_nxt       = rst_r;
    if (start_stream || (store && pend_refresh_r)) begin
      streaming_nxt = 1'b1;
      rst_phase_nxt = 1'b0;
      led_nxt       = '0;
      bit_nxt       = '0;
      rst_nxt       = '0;
    end else if (emit) begin
      if (word_last) begin
        streaming_nxt = 1'b0;
        rst_phase_nxt = 1'b0;
        led_nxt       = '0;
        bit_nxt       = '0;
        rst_nxt       = '0;
      end else if (rst_phase_r) begin
        rst_nxt = rst_r + 1'b1;
      end else if (bit_last) begin
        bit_nxt = '0;
        if (led_last) begin
          rst_phase_nxt = 1'b1;
          rst_nxt       = '0;
        end else begin
          led_nxt = led_r + 1'b1;
        end
      end else begin
        bit_nxt = bit_r + 1'b1;
      end
    end
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_duty_nxt  = out_duty_r;
    out_last_nxt  = out_last_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_duty_nxt  = word;
      out_last_nxt  = word_last;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      streaming_r <= 1'b0;
      rst_phase_r <= 1'b0;
      led_r       <= '0;
      bit_r       <= '0;
      rst_r       <= '0;
      out_valid_r <= 1'b0;
      valid_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      streaming_r <= streaming_nxt;
      rst_phase_r <= rst_phase_nxt;
      led_r       <= led_nxt;
      bit_r       <= bit_nxt;
      rst_r       <= rst_nxt;
      out_valid_r <= out_valid_nxt;
      if (store) begin
        valid_r[LED_AW'(pend_slot_r)] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_duty_r <= out_duty_nxt;
    out_last_r <= out_last_nxt;
    if (div_start) begin
      pend_slot_r    <= head.slot;
      pend_refresh_r <= head.refresh;
    end
  end

  // frame store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (store) begin
      mem[LED_AW'(pend_slot_r)] <= {div_quo[0], div_quo[1], div_quo[2]};
    end
    rdata_r <= mem[led_r];
  end

  assign out_tvalid     = out_valid_r;
  assign out_tdata      = out_duty_r;
  assign out_tlast      = out_last_r;
  assign stat.streaming = streaming_r;
  assign stat.emit      = emit;
  assign stat.div_busy  = div_busy;

endmodule

// File: hw/rtl/led_matrix_pwm_frame_streamer_core.sv
// top level of the led matrix pwm frame streamer
//
//  port group | dir | contents
//  -----------+-----+---------------------------------------------------------
//  in_*       | in  | action in tuser; led write fields and refresh flag in tdata
//  out_*      | out | one pwm duty word per tick, tlast on the final word
//  cfg_*      | in  | write-only duty registers, index 0 one-bit, 1 zero-bit
//
//  a tick passes through the queue, frame store read port and output
//  register; a led write goes through the 8-step restoring divider
//  rst_n is synchronous: frame store entries read as zero until written,
//  stream goes idle, duties clear; no clearing pass is needed
//  a stalled output register holds the back end, the two-entry queue lets the
//  input side keep taking items meanwhile until the queue is full
`include "led_matrix_pwm_frame_streamer_core_defines.svh"

module led_matrix_pwm_frame_streamer_core #(
  parameter int LED_COUNT   = lmps_pkg::LED_COUNT_DEF,
  parameter int RESET_SLOTS = lmps_pkg::RESET_SLOTS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // column, row, color_a, color_b, color_c, divisor, refresh_after, zero pad
  input  logic [lmps_pkg::IN_TDATA_W-1:0]   in_tdata,
  // action
  input  logic [lmps_pkg::IN_TUSER_W-1:0]   in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // duty
  output logic [lmps_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic                              out_tlast,
  input  logic                              cfg_we,
  input  logic [lmps_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lmps_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import lmps_pkg::*;

  front_req_t req;
  cmd_t       head;
  logic       fifo_empty;
  logic       fifo_full;
  logic       pop;
  back_stat_t stat;
  duty_cfg_t  duty_r;
  duty_cfg_t  duty_nxt;

  // duty registers, index beyond the list is ignored
  always_comb begin
    duty_nxt = duty_r;
    if (cfg_we) begin
      if (cfg_index == REG_ONE_DUTY) begin
        duty_nxt.one = DUTY_W'(cfg_wdata);
      end else if (cfg_index == REG_ZERO_DUTY) begin
        duty_nxt.zero = DUTY_W'(cfg_wdata);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      duty_r <= '0;
    end else begin
      duty_r <= duty_nxt;
    end
  end

  // decode and check incoming items
  lmps_front #(
    .LED_COUNT (LED_COUNT)
  ) u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .fifo_full (fifo_full),
    .req       (req)
  );

  // command queue decouples intake from execution
  lmps_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .pop   (pop),
    .head  (head),
    .empty (fifo_empty),
    .full  (fifo_full)
  );

  // frame store, divider, stream sequencer, output register
  lmps_back #(
    .LED_COUNT   (LED_COUNT),
    .RESET_SLOTS (RESET_SLOTS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .fifo_empty (fifo_empty),
    .pop        (pop),
    .duty       (duty_r),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .stat       (stat)
  );

  // a word is produced only while a refresh runs
  `LMPS_ASSERT_IMPL(a_emit_only_streaming, stat.emit, stat.streaming)
  // a produced word lands in the output register
  `LMPS_ASSERT_NEXT(a_emit_loads_output, stat.emit, out_tvalid)
  // the divider never runs during a refresh
  `LMPS_ASSERT_IMPL(a_div_idle_streaming, stat.div_busy, !stat.streaming)

endmodule

// File: tb/led_matrix_pwm_frame_streamer_core_check.sv
// scoreboard for the led matrix frame streamer: predicts every pwm word and compares it
`timescale 1ns / 100ps
module led_matrix_pwm_frame_streamer_core_check
  import lmps_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic [IN_TUSER_W-1:0]  in_tuser,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   out_tlast,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  output int                     mismatch_count,
  output int                     words_pending
);

  localparam int DATA_WORDS  = LED_COUNT_DEF * BITS_PER_LED;
  localparam int FRAME_WORDS = DATA_WORDS + RESET_SLOTS_DEF;

  typedef struct packed {
    logic [DUTY_W-1:0] duty;
    logic              last;
  } pwm_word_t;

  logic [BITS_PER_LED-1:0] led_colors [LED_COUNT_DEF];
  logic                    refresh_on;
  logic [10:0]             word_pos;
  logic [DUTY_W-1:0]       one_duty;
  logic [DUTY_W-1:0]       zero_duty;
  pwm_word_t               duty_words [$];

  // one line per mismatch, and the count
  task automatic note_mismatch(input string what);
    mismatch_count = mismatch_count + 1;
    $display("%0t ns: mismatch, %s", $time, what);
  endtask

  task automatic predict_item(input logic [IN_TUSER_W-1:0] act,
                              input logic [IN_TDATA_W-1:0] data);
    logic [7:0] col;
    logic [7:0] row;
    logic [7:0] dv;
    int         slot;
    int         led_idx;
    int         bit_idx;
    pwm_word_t  w;
    col = data[7:0];
    row = data[15:8];
    dv  = data[47:40];
    case (act)
      ACT_TICK: if (refresh_on) begin
        if (word_pos >= DATA_WORDS) begin
          w.duty = zero_duty;
        end else begin
          led_idx = word_pos / BITS_PER_LED;
          bit_idx = BITS_PER_LED - 1 - (word_pos % BITS_PER_LED);
          w.duty  = led_colors[led_idx][bit_idx] ? one_duty : zero_duty;
        end
        word_pos = word_pos + 11'd1;
        w.last   = (word_pos >= FRAME_WORDS);
        if (w.last) begin
          refresh_on = 1'b0;
          word_pos   = '0;
        end
        duty_words.push_back(w);
      end
      ACT_WRITE: if (!refresh_on && dv != 0 && col <= MAX_COORD && row <= MAX_COORD) begin
        slot = row * MATRIX_SIDE + col;
        if (slot < LED_COUNT_DEF) begin
          led_colors[slot] = {data[23:16] / dv, data[31:24] / dv, data[39:32] / dv};
          if (data[48]) begin
            refresh_on = 1'b1;
            word_pos   = '0;
          end
        end
      end
      ACT_REFRESH: if (!refresh_on) begin
        refresh_on = 1'b1;
        word_pos   = '0;
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin : watch
    pwm_word_t want;
    if (!rst_n) begin
      for (int i = 0; i < LED_COUNT_DEF; i++) led_colors[i] = '0;
      refresh_on = 1'b0;
      word_pos   = '0;
      one_duty   = '0;
      zero_duty  = '0;
      duty_words.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (duty_words.size() == 0) begin
          note_mismatch($sformatf("duty %h arrived with no word expected", out_tdata));
        end else begin
          want = duty_words.pop_front();
          if (out_tdata !== want.duty)
            note_mismatch($sformatf("duty %h, expected %h", out_tdata, want.duty));
          if (out_tlast !== want.last)
            note_mismatch($sformatf("tlast %b, expected %b", out_tlast, want.last));
        end
      end
      if (cfg_we) begin
        if (cfg_index == REG_ONE_DUTY) one_duty = cfg_wdata;
        else if (cfg_index == REG_ZERO_DUTY) zero_duty = cfg_wdata;
      end
      if (in_tvalid && in_tready) predict_item(in_tuser, in_tdata);
    end
    words_pending = duty_words.size();
  end

endmodule

// File: tb/led_matrix_pwm_frame_streamer_core_test.sv
// stimulus and verdict for the led matrix pwm frame streamer
`timescale 1ns / 100ps
module led_matrix_pwm_frame_streamer_core_test;
  import lmps_pkg::*;

  // action code the block must ignore
  localparam logic [IN_TUSER_W-1:0] ACT_UNUSED  = 2'd3;
  // register indexes past the last duty register, writes there are dropped
  localparam logic [CFG_IDX_W-1:0]  REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0]  REG_SPARE_B = 2'd3;
  localparam int FRAME_WORDS  = LED_COUNT_DEF * BITS_PER_LED + RESET_SLOTS_DEF;
  localparam int RANDOM_ITEMS = 650;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;   // column, row, color_a, color_b, color_c, divisor, refresh_after
  logic [IN_TUSER_W-1:0]  in_tuser;   // action
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;  // duty
  logic                   out_tlast;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wdata;

  int   fail_count;
  int   pending;
  int   words_left;   // stimulus-side view of the words still owed by the running refresh
  int   sent;
  logic hold_go = 1'b0;

  always #4 clk = ~clk;

  led_matrix_pwm_frame_streamer_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  led_matrix_pwm_frame_streamer_core_check check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tlast      (out_tlast),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .mismatch_count (fail_count),
    .words_pending  (pending)
  );

  // pack the led write fields, pad bits stay zero
  function automatic logic [IN_TDATA_W-1:0] led_fields(
    input logic [7:0] col, input logic [7:0] row, input logic [7:0] a,
    input logic [7:0] b, input logic [7:0] c, input logic [7:0] dv, input logic rf);
    return {7'd0, rf, dv, c, b, a, row, col};
  endfunction

  function automatic logic [IN_TDATA_W-1:0] any_fields();
    return led_fields(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                      8'($urandom), 8'($urandom), 1'($urandom));
  endfunction

  // color byte with the extremes showing up often
  function automatic logic [7:0] shade();
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hff;
      default: return 8'($urandom);
    endcase
  endfunction

  // offer one item and wait for it to be taken; random gaps except in the steady window
  task automatic offer(input logic [IN_TUSER_W-1:0] act, input logic [IN_TDATA_W-1:0] data);
    int gap;
    gap = 0;
    if (!(sent >= 300 && sent < 900) && $urandom_range(99) < 14) gap = $urandom_range(3, 1);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= data;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent++;
    // track the refresh so the tick runs stop right after the final word
    case (act)
      ACT_TICK: if (words_left > 0) words_left--;
      ACT_WRITE:
        if (words_left == 0 && data[48] && data[47:40] != 0 &&
            data[7:0] <= MAX_COORD && data[15:8] <= MAX_COORD)
          words_left = FRAME_WORDS;
      ACT_REFRESH: if (words_left == 0) words_left = FRAME_WORDS;
      default: ;
    endcase
  endtask

  // well-formed led write, divisor leaning to small values so colors survive
  task automatic write_led(input logic rf);
    logic [7:0] dv;
    case ($urandom_range(9))
      0, 1, 2, 3: dv = 8'd1;
      4, 5:       dv = 8'($urandom_range(4, 2));
      default:    dv = 8'($urandom_range(255, 1));
    endcase
    offer(ACT_WRITE, led_fields(8'($urandom_range(MAX_COORD)), 8'($urandom_range(MAX_COORD)),
                                shade(), shade(), shade(), dv, rf));
  endtask

  // tick until the frame is out, with a sprinkle of items that must be ignored mid-stream
  task automatic run_refresh();
    int pick;
    hold_go <= 1'b1;
    while (words_left > 0) begin
      pick = $urandom_range(99);
      if (pick < 2)
        offer(ACT_WRITE, led_fields(8'($urandom_range(MAX_COORD)),
                                    8'($urandom_range(MAX_COORD)), shade(), shade(),
                                    shade(), 8'($urandom_range(255, 1)), 1'b1));
      else if (pick < 4) offer(ACT_REFRESH, any_fields());
      else if (pick < 5) offer(ACT_UNUSED, any_fields());
      else offer(ACT_TICK, any_fields());
    end
  endtask

  // quiet the input and let the back end drain, writes can still be in the divider
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  // receiver: random stalls, a long hold-off once the first refresh runs, a clean stretch, then random
  initial begin : receiver
    out_tready <= 1'b0;
    while (!hold_go) begin
      @(posedge clk);
      out_tready <= ($urandom_range(99) >= 14);
    end
    repeat (300) begin
      @(posedge clk);
      out_tready <= 1'b0;
    end
    repeat (500) begin
      @(posedge clk);
      out_tready <= 1'b1;
    end
    forever begin
      @(posedge clk);
      out_tready <= ($urandom_range(99) >= 14);
    end
  end

  initial begin : stimulus
    int phase;
    int rand_start;
    int n;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tuser   <= ACT_TICK;
    cfg_we     <= 1'b0;
    cfg_index  <= REG_ONE_DUTY;
    cfg_wdata  <= '0;
    rst_n      <= 1'b0;
    words_left = 0;
    sent       = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // spare indexes first, they must not disturb the duties
    set_reg(REG_SPARE_A, 16'($urandom));
    set_reg(REG_SPARE_B, 16'($urandom));
    set_reg(REG_ONE_DUTY, 16'hffff);
    set_reg(REG_ZERO_DUTY, 16'h0000);
    cfg_we <= 1'b0;

    // idle tick and unused action give nothing
    offer(ACT_TICK, '0);
    offer(ACT_UNUSED, led_fields(8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 1'b1));
    // invalid writes: zero divisor, coordinates off the matrix; no refresh either
    offer(ACT_WRITE, led_fields(8'd0, 8'd0, 8'hff, 8'hff, 8'hff, 8'd0, 1'b1));
    offer(ACT_WRITE, led_fields(8'd8, 8'd0, 8'hff, 8'hff, 8'hff, 8'd1, 1'b1));
    offer(ACT_WRITE, led_fields(8'd0, 8'd255, 8'hff, 8'hff, 8'hff, 8'd1, 1'b1));
    offer(ACT_WRITE, led_fields(8'd255, 8'd8, 8'hff, 8'hff, 8'hff, 8'd1, 1'b1));
    // corners and a spread of divisors
    offer(ACT_WRITE, led_fields(8'd0, 8'd0, 8'hff, 8'h00, 8'ha5, 8'd1, 1'b0));
    offer(ACT_WRITE, led_fields(8'd7, 8'd7, 8'hff, 8'hff, 8'hff, 8'd255, 1'b0));
    offer(ACT_WRITE, led_fields(8'd7, 8'd0, 8'h80, 8'h01, 8'hfe, 8'd2, 1'b0));
    offer(ACT_WRITE, led_fields(8'd0, 8'd7, 8'hff, 8'hff, 8'hff, 8'd1, 1'b0));
    offer(ACT_WRITE, led_fields(8'd3, 8'd4, 8'h7f, 8'hc3, 8'h3c, 8'd3, 1'b0));
    offer(ACT_WRITE, led_fields(8'd1, 8'd0, 8'hff, 8'h80, 8'h01, 8'd128, 1'b0));
    // overwrite of an led already set
    offer(ACT_WRITE, led_fields(8'd0, 8'd0, 8'h12, 8'h34, 8'h56, 8'd1, 1'b0));
    // refresh start, then the things that must be ignored while streaming
    offer(ACT_REFRESH, '0);
    offer(ACT_REFRESH, '0);
    offer(ACT_WRITE, led_fields(8'd5, 8'd5, 8'hff, 8'hff, 8'hff, 8'd1, 1'b1));
    offer(ACT_UNUSED, '0);
    run_refresh();

    // random phases: new duties, a batch of writes with some noise, then a full frame
    phase      = 0;
    rand_start = sent;
    while (phase < 2 || sent - rand_start < RANDOM_ITEMS) begin
      settle();
      if (phase == 0) begin
        set_reg(REG_ONE_DUTY, 16'h0000);
        set_reg(REG_ZERO_DUTY, 16'hffff);
      end else begin
        set_reg(REG_ONE_DUTY, 16'($urandom));
        set_reg(REG_ZERO_DUTY, 16'($urandom));
      end
      cfg_we <= 1'b0;
      n = $urandom_range(40, 10);
      repeat (n) begin
        if ($urandom_range(99) < 15) begin
          case ($urandom_range(4))
            0: offer(ACT_TICK, any_fields());
            1: offer(ACT_WRITE, any_fields());
            2: offer(ACT_UNUSED, any_fields());
            3: offer(ACT_WRITE, led_fields(8'($urandom_range(255, 8)), 8'($urandom),
                                           shade(), shade(), shade(),
                                           8'($urandom_range(255, 1)), 1'b1));
            default: offer(ACT_WRITE, led_fields(8'($urandom_range(MAX_COORD)),
                                                 8'($urandom_range(MAX_COORD)), shade(),
                                                 shade(), shade(), 8'd0, 1'b1));
          endcase
        end else begin
          write_led(1'b0);
        end
        // a noise write can land valid with refresh set
        if (words_left > 0) run_refresh();
      end
      if ($urandom_range(1)) write_led(1'b1);
      else offer(ACT_REFRESH, any_fields());
      run_refresh();
      phase++;
    end

    settle();
    repeat (20) @(posedge clk);
    if (fail_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  initial begin : watchdog
    #(5_000_000);
    $display("DONE: errors detected");
    $finish;
  end

endmodule
